// File: design/hashed_block_buffer_cache_lru_core_defines.svh
// assertion macros used by the buffer cache sequencer (hbc_ctrl)
`ifndef HASHED_BLOCK_BUFFER_CACHE_LRU_CORE_DEFINES_SVH
`define HASHED_BLOCK_BUFFER_CACHE_LRU_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/hbc_pkg.sv
// shared types and constants of the buffer cache directory
`default_nettype none
package hbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int NUM_BUCKETS = 13;
  localparam int IDX_W   = $clog2(NUM_BUFFERS);
  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 31;
  localparam int SLOT_W  = 5;
  localparam int CNT_W   = 16;
  localparam int STAMP_W = 32;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PIN     = 2'd2,
    ACT_UNPIN   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_UNDER   = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   blk;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] stamp;
    logic               cv;
  } entry_t;

  typedef struct packed {
    action_t             action;
    logic [DEV_W-1:0]    device;
    logic [BLK_W-1:0]    block_number;
    logic [SLOT_W-1:0]   slot;
    logic [STAMP_W-1:0]  tick;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              hit;
    logic              needs_fill;
    status_t           status;
  } res_t;

endpackage
`default_nettype wire

// File: design/hashed_block_buffer_cache_lru_core.sv
// Hashed block buffer cache directory with LRU replacement, top level.
// One request word enters on s_axis (action in tuser), one result word
// leaves on m_axis for every request.
// get: the home bucket is block_number mod 13, found four bits a cycle.
// Every slot of the entry memory is then read once, one per cycle,
// and compared for a hit and for the best unreferenced victim at once.
// A get is paced by the one read port of the entry memory walked over all
// 32 slots; release, pin and unpin read the slot and write it back in S_OP.
// One request is worked on at a time; s_axis_tready is high while idle.
// Results sit in an output register: the next request is taken while a result
// still waits, and a stalled m_axis holds the finished item until taken.
// Reset (rst, synchronous) empties the directory: every slot is tagged
// device 0 block 0, count 0, in bucket 0. It needs no clearing pass.
`default_nettype none
module hashed_block_buffer_cache_lru_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // device[7:0], block_number[38:8], slot[43:39], tick[75:44], zero pad
  input  wire logic [79:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // slot_out[4:0], hit[5], needs_fill[6], status[8:7], zero pad
  output logic [15:0]      m_axis_tdata
);
  import hbc_pkg::*;

  req_t req;
  res_t res;
  res_t out_q;
  logic res_valid;
  logic res_take;

  always_comb begin
    req.action       = action_t'(s_axis_tuser);
    req.device       = s_axis_tdata[7:0];
    req.block_number = s_axis_tdata[38:8];
    req.slot         = s_axis_tdata[43:39];
    req.tick         = s_axis_tdata[75:44];
  end

  hbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register frees the sequencer while the sink stalls
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {7'b0, out_q.status, out_q.needs_fill, out_q.hit, out_q.slot_out};

endmodule
`default_nettype wire

// File: design/hbc_entry_ram.sv
// per-slot entry memory with registered read and reset-cleared valid bits
`default_nettype none
module hbc_entry_ram (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [hbc_pkg::IDX_W-1:0]  rd_addr,
  output hbc_pkg::entry_t                 rd_data,
  input  wire logic                       wr_en,
  input  wire logic [hbc_pkg::IDX_W-1:0]  wr_addr,
  input  wire hbc_pkg::entry_t            wr_data
);
  import hbc_pkg::*;

  entry_t                 mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] vld;
  entry_t                 rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // never-written entries read as the reset value
  assign rd_data = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

// File: design/hbc_ctrl.sv
// sequencer: home bucket, slot scan, read-modify-write of the entry memory
`default_nettype none
`include "hashed_block_buffer_cache_lru_core_defines.svh"
module hbc_ctrl (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire hbc_pkg::req_t in_req,
  output logic       res_valid,
  input  wire logic  res_take,
  output hbc_pkg::res_t res
);
  import hbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_SCAN, S_DECIDE, S_OP, S_DONE
  } state_t;

  state_t state;
  req_t   req;

  // bucket membership and insertion rank, updated in parallel on a move
  logic [BKT_W-1:0] bucket [NUM_BUFFERS];
  logic [IDX_W-1:0] rank   [NUM_BUFFERS];

  logic [BKT_W-1:0] home;
  logic [31:0]      mod_sh;
  logic [2:0]       mod_cnt;

  logic [IDX_W:0]   iss;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;

  logic             hit_f;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  entry_t           hit_ent;

  logic             pick_f;
  logic [IDX_W-1:0] pick_idx;
  logic [IDX_W-1:0] pick_rank;
  logic [BKT_W-1:0] pick_dist;
  logic [STAMP_W-1:0] pick_stamp;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  hbc_entry_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // four steps of remainder by the bucket count, msb first
  function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] r_in,
                                                input logic [3:0] nib);
    logic [BKT_W:0]   t;
    logic [BKT_W-1:0] r;
    r = r_in;
    for (int b = 3; b >= 0; b--) begin
      t = {r, nib[b]};
      if (t >= (BKT_W+1)'(NUM_BUCKETS)) begin
        t = t - (BKT_W+1)'(NUM_BUCKETS);
      end
      r = t[BKT_W-1:0];
    end
    return r;
  endfunction

  // compare stage of the scan
  logic [BKT_W-1:0] c_bkt;
  logic [IDX_W-1:0] c_rank;
  logic [BKT_W:0]   c_dist_w;
  logic [BKT_W-1:0] c_dist;
  logic             c_match;
  logic             c_hit_better;
  logic             c_free;
  logic             c_pick_better;

  always_comb begin
    c_bkt  = bucket[cmp_idx];
    c_rank = rank[cmp_idx];
    if (c_bkt >= home) begin
      c_dist_w = {1'b0, c_bkt} - {1'b0, home};
    end else begin
      c_dist_w = {1'b0, c_bkt} + (BKT_W+1)'(NUM_BUCKETS) - {1'b0, home};
    end
    c_dist  = c_dist_w[BKT_W-1:0];
    c_match = (c_bkt == home) && (rd_data.dev == req.device) &&
              (rd_data.blk == req.block_number);
    c_hit_better = c_match && (!hit_f || (c_rank > hit_rank));
    c_free  = (rd_data.cnt == '0);
    c_pick_better = c_free && (!pick_f || (c_dist < pick_dist) ||
                    ((c_dist == pick_dist) && ((rd_data.stamp < pick_stamp) ||
                    ((rd_data.stamp == pick_stamp) && (c_rank > pick_rank)))));
  end

  logic scan_end;
  assign scan_end = (iss == (IDX_W+1)'(NUM_BUFFERS)) && !cmp_vld;

  // read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = iss[IDX_W-1:0];
    if (state == S_IDLE) begin
      rd_en   = in_valid && (in_req.action != ACT_GET);
      rd_addr = in_req.slot[IDX_W-1:0];
    end else if (state == S_SCAN) begin
      rd_en = (iss < (IDX_W+1)'(NUM_BUFFERS));
    end
  end

  // write port and result of the current item
  res_t   res_next;
  logic   moved;
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = hit_idx;
    wr_data  = hit_ent;
    res_next = '0;
    moved    = 1'b0;
    if (state == S_DECIDE) begin
      if (hit_f) begin
        wr_en   = 1'b1;
        wr_data = hit_ent;
        if (hit_ent.cnt != '1) begin
          wr_data.cnt = hit_ent.cnt + CNT_W'(1);
        end
        wr_data.stamp       = req.tick;
        wr_data.cv          = 1'b1;
        res_next.slot_out   = SLOT_W'(hit_idx);
        res_next.hit        = 1'b1;
        res_next.needs_fill = !hit_ent.cv;
        res_next.status     = ST_OK;
      end else if (pick_f) begin
        wr_en         = 1'b1;
        wr_addr       = pick_idx;
        wr_data.dev   = req.device;
        wr_data.blk   = req.block_number;
        wr_data.cnt   = CNT_W'(1);
        wr_data.stamp = req.tick;
        wr_data.cv    = 1'b1;
        moved         = (bucket[pick_idx] != home);
        res_next.slot_out   = SLOT_W'(pick_idx);
        res_next.needs_fill = 1'b1;
        res_next.status     = ST_OK;
      end else begin
        res_next.status = ST_NO_FREE;
      end
    end else if (state == S_OP) begin
      wr_en             = 1'b1;
      wr_addr           = req.slot[IDX_W-1:0];
      wr_data           = rd_data;
      res_next.slot_out = req.slot;
      res_next.status   = ST_OK;
      if (req.action == ACT_PIN) begin
        if (rd_data.cnt != '1) begin
          wr_data.cnt = rd_data.cnt + CNT_W'(1);
        end
      end else begin
        if (rd_data.cnt == '0) begin
          res_next.status = ST_UNDER;
        end else begin
          wr_data.cnt = rd_data.cnt - CNT_W'(1);
        end
        if (req.action == ACT_RELEASE) begin
          wr_data.stamp = req.tick;
        end
      end
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cmp_vld <= 1'b0;
      iss     <= '0;
      hit_f   <= 1'b0;
      pick_f  <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        bucket[i] <= '0;
        rank[i]   <= IDX_W'(NUM_BUFFERS - 1 - i);
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_req;
            if (in_req.action == ACT_GET) begin
              mod_sh  <= {1'b0, in_req.block_number};
              mod_cnt <= '0;
              home    <= '0;
              state   <= S_MOD;
            end else begin
              state <= S_OP;
            end
          end
        end
        S_MOD: begin
          home    <= mod_step(home, mod_sh[31:28]);
          mod_sh  <= {mod_sh[27:0], 4'b0};
          mod_cnt <= mod_cnt + 3'd1;
          if (mod_cnt == 3'd7) begin
            iss     <= '0;
            cmp_vld <= 1'b0;
            hit_f   <= 1'b0;
            pick_f  <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            iss <= iss + (IDX_W+1)'(1);
          end
          cmp_vld <= rd_en;
          cmp_idx <= iss[IDX_W-1:0];
          if (cmp_vld && c_hit_better) begin
            hit_f    <= 1'b1;
            hit_idx  <= cmp_idx;
            hit_rank <= c_rank;
            hit_ent  <= rd_data;
          end
          if (cmp_vld && c_pick_better) begin
            pick_f     <= 1'b1;
            pick_idx   <= cmp_idx;
            pick_rank  <= c_rank;
            pick_dist  <= c_dist;
            pick_stamp <= rd_data.stamp;
          end
          if (scan_end) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res <= res_next;
          if (moved) begin
            // taken from another bucket: becomes the newest in its home list
            for (int i = 0; i < NUM_BUFFERS; i++) begin
              if (rank[i] > rank[pick_idx]) begin
                rank[i] <= rank[i] - IDX_W'(1);
              end
            end
            rank[pick_idx]   <= IDX_W'(NUM_BUFFERS - 1);
            bucket[pick_idx] <= home;
          end
          state <= S_DONE;
        end
        S_OP: begin
          res   <= res_next;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HBC_ASSERT_NOW(a_scan_bound, 1'b1, iss <= (IDX_W+1)'(NUM_BUFFERS), "scan ran past the last slot")
  `HBC_ASSERT_NOW(a_hit_ok, res_valid && res.hit, res.status == ST_OK, "hit with bad status")
  `HBC_ASSERT_NEXT(a_wr_done, wr_en, state == S_DONE, "write outside of item finish")
  `HBC_ASSERT_NEXT(a_res_hold, res_valid && !res_take, res_valid && $stable(res), "result lost")

endmodule
`default_nettype wire
